### rtl/assert_macros.svh
// Assertion macros for the RTL; included by the top level.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### rtl/tvpns_pkg.sv
// Shared types and constants of the three-voice pulse/noise synth.
// No dependencies.
package tvpns_pkg;
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ON   = 2'd1;
    localparam logic [1:0] CMD_OFF  = 2'd2;

    localparam logic [2:0] REG_DUTY0  = 3'd0;
    localparam logic [2:0] REG_DUTY1  = 3'd1;
    localparam logic [2:0] REG_LFO0   = 3'd2;
    localparam logic [2:0] REG_LFO1   = 3'd3;
    localparam logic [2:0] REG_GLIDE0 = 3'd4;
    localparam logic [2:0] REG_GLIDE1 = 3'd5;

    localparam logic [22:0] NOISE_SEED = 23'h1F37A5;
    localparam logic [7:0]  DUTY_RESET = 8'd128;
    localparam int          DIV_STEPS  = 32;

    typedef enum logic [2:0] {
        ST_IDLE, ST_TICK, ST_DIV_LOAD, ST_DIV, ST_DIV_DONE, ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic tick;      // advance both pulse voices and an enabled noise voice, load result
        logic note;      // apply note on/off directly
        logic div_load;  // capture glide operands
        logic div_step;  // one restoring division step
        logic div_done;  // write glide step
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic glide;     // note on needs a glide division
    } t_status;
endpackage

### rtl/tvpns_ctrl.sv
// Controller of the synth: sequences ticks, notes and the glide divider.
// Depends on tvpns_pkg.
module tvpns_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_command,
    input  logic                i_out_free,
    input  tvpns_pkg::t_status  i_status,
    output logic                o_in_ready,
    output tvpns_pkg::t_cmd     o_cmd
);
    tvpns_pkg::t_state r_state, n_state;
    logic [5:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tvpns_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            tvpns_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_command == tvpns_pkg::CMD_TICK) begin
                        n_state = i_out_free ? tvpns_pkg::ST_OUT : tvpns_pkg::ST_IDLE;
                    end else if (i_command == tvpns_pkg::CMD_ON && i_status.glide) begin
                        n_state = tvpns_pkg::ST_DIV_LOAD;
                    end else begin
                        n_state = tvpns_pkg::ST_IDLE;
                    end
                end
            end
            tvpns_pkg::ST_DIV_LOAD: begin
                n_state = tvpns_pkg::ST_DIV;
                n_cnt   = '0;
            end
            tvpns_pkg::ST_DIV: begin
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(tvpns_pkg::DIV_STEPS - 1)) n_state = tvpns_pkg::ST_DIV_DONE;
            end
            tvpns_pkg::ST_DIV_DONE: n_state = tvpns_pkg::ST_IDLE;
            tvpns_pkg::ST_OUT:      n_state = tvpns_pkg::ST_IDLE;
            default:                n_state = tvpns_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            tvpns_pkg::ST_IDLE: begin
                o_in_ready = (i_command != tvpns_pkg::CMD_TICK) || i_out_free;
                if (i_in_valid && o_in_ready) begin
                    o_cmd.tick = (i_command == tvpns_pkg::CMD_TICK);
                    // only a note on can start a glide; a note off always applies directly
                    o_cmd.note = (i_command != tvpns_pkg::CMD_TICK)
                               && !((i_command == tvpns_pkg::CMD_ON) && i_status.glide);
                    o_cmd.div_load = (i_command == tvpns_pkg::CMD_ON) && i_status.glide;
                end
            end
            tvpns_pkg::ST_DIV:      o_cmd.div_step = 1'b1;
            tvpns_pkg::ST_DIV_DONE: o_cmd.div_done = 1'b1;
            default: ;
        endcase
    end
endmodule

### rtl/tvpns_dp.sv
// Datapath of the synth: accumulators, LFOs, glide, LFSR, serial divider.
// Depends on tvpns_pkg.
module tvpns_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tvpns_pkg::t_cmd     i_cmd,
    input  logic [1:0]          i_command,
    input  logic [1:0]          i_voice,
    input  logic [31:0]         i_increment,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_out_take,
    output tvpns_pkg::t_status  o_status,
    output logic                o_out_valid,
    output logic [2:0]          o_levels
);
    logic [7:0]  r_duty [2];
    logic [31:0] r_lfo_rate [2];
    logic [15:0] r_glide_ms [2];
    logic [31:0] r_phase [2];
    logic [31:0] r_inc [3];
    logic [31:0] r_lfo_ph [2];
    logic [31:0] r_tgt [2];
    logic [31:0] r_step [2];
    logic [6:0]  r_tick_cnt;
    logic [22:0] r_lfsr;
    logic [31:0] r_nphase;
    logic        r_nen;
    logic        r_out_valid;
    logic [2:0]  r_levels;
    // glide divider
    logic        r_dv;
    logic [31:0] r_dinc;
    logic        r_neg, r_dnz;
    logic [31:0] r_quo;
    logic [23:0] r_ticks;
    logic [32:0] r_rem;
    logic [21:0] n_ms61;
    logic [42:0] n_recip;
    logic [23:0] n_ticks;
    logic [31:0] n_diff, n_mag;
    logic [32:0] n_trial;
    logic [31:0] n_inc_g [2];
    logic [31:0] n_lp [2];
    logic        n_lv [2];
    logic [31:0] n_nph;
    logic [22:0] n_lfsr;
    logic        n_vsel;
    logic        n_wrap;

    function automatic logic [7:0] n_phase_top(input logic [31:0] ph, input logic [31:0] inc);
        logic [31:0] s;
        s = ph + inc;
        return s[31:24];
    endfunction

    assign n_vsel = i_voice[0];
    assign o_status.glide = (i_voice[1] == 1'b0) && (r_glide_ms[n_vsel] != 16'd0)
                          && (r_inc[n_vsel] != 32'd0);
    assign n_wrap = (r_tick_cnt == 7'h7F);
    assign o_out_valid = r_out_valid;
    assign o_levels = r_levels;

    always_comb begin
        for (int v = 0; v < 2; v++) begin
            logic [31:0] d;
            logic        pos_hit, neg_hit;
            logic [7:0]  b, duty;
            d = r_tgt[v] - r_inc[v];
            pos_hit = !r_step[v][31] && ($signed(d) <= $signed(r_step[v]));
            neg_hit = r_step[v][31] && ($signed(d) >= $signed(r_step[v]));
            n_inc_g[v] = r_inc[v];
            if (n_wrap && r_step[v] != 32'd0 && r_inc[v] != r_tgt[v])
                n_inc_g[v] = (pos_hit || neg_hit) ? r_tgt[v] : r_inc[v] + r_step[v];
            n_lp[v] = r_lfo_ph[v] + r_lfo_rate[v];
            b = n_lp[v][31] ? ~n_lp[v][31:24] : n_lp[v][31:24];
            duty = (r_lfo_rate[v] != 32'd0) ? {1'b0, b[6:0]} + 8'd64 : r_duty[v];
            n_lv[v] = (n_inc_g[v] != 32'd0) && (n_phase_top(r_phase[v], r_inc[v]) < duty);
        end
        n_nph  = r_nphase + r_inc[2];
        n_lfsr = r_lfsr;
        if (!r_nphase[31] && n_nph[31]) n_lfsr = {r_lfsr[21:0], r_lfsr[22] ^ r_lfsr[17]};
        n_diff  = i_increment - r_inc[n_vsel];
        n_mag   = n_diff[31] ? 32'd0 - n_diff : n_diff;
        // ms*244/1000 = ((ms*61) >> 1) / 125; divide by 125 through a 2^28 reciprocal,
        // exact for the 21-bit dividend
        n_ms61  = 22'(r_glide_ms[n_vsel]) * 22'd61;
        n_recip = 43'(n_ms61[21:1]) * 43'd2147484;
        n_ticks = {9'd0, n_recip[42:28]};
        n_trial = {r_rem[31:0], r_dinc[31]} - {9'd0, r_ticks};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < 2; v++) begin
                r_duty[v] <= tvpns_pkg::DUTY_RESET;
                r_lfo_rate[v] <= '0;
                r_glide_ms[v] <= '0;
                r_phase[v] <= '0;
                r_lfo_ph[v] <= '0;
                r_tgt[v] <= '0;
                r_step[v] <= '0;
            end
            for (int v = 0; v < 3; v++) r_inc[v] <= '0;
            r_tick_cnt  <= '0;
            r_lfsr      <= tvpns_pkg::NOISE_SEED;
            r_nphase    <= '0;
            r_nen       <= 1'b0;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
        end else begin
            if (i_out_take) r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tvpns_pkg::REG_DUTY0:  r_duty[0] <= i_cfg_data[7:0];
                    tvpns_pkg::REG_DUTY1:  r_duty[1] <= i_cfg_data[7:0];
                    tvpns_pkg::REG_LFO0, tvpns_pkg::REG_LFO1: begin
                        r_lfo_rate[i_cfg_index[0]] <= i_cfg_data;
                        r_lfo_ph[i_cfg_index[0]] <= '0;
                    end
                    tvpns_pkg::REG_GLIDE0, tvpns_pkg::REG_GLIDE1: begin
                        r_glide_ms[i_cfg_index[0]] <= i_cfg_data[15:0];
                        if (i_cfg_data[15:0] == 16'd0) r_step[i_cfg_index[0]] <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.tick) begin
                for (int v = 0; v < 2; v++) begin
                    r_phase[v] <= r_phase[v] + r_inc[v];
                    r_inc[v] <= n_inc_g[v];
                    if (n_inc_g[v] != 32'd0 && r_lfo_rate[v] != 32'd0) r_lfo_ph[v] <= n_lp[v];
                end
                r_tick_cnt <= r_tick_cnt + 7'd1;
                if (r_nen) begin
                    r_nphase <= n_nph;
                    r_lfsr   <= n_lfsr;
                end
                r_out_valid <= 1'b1;
                r_levels <= {r_nen && (n_lfsr[0] ^ n_lfsr[2] ^ n_lfsr[5] ^ n_lfsr[9]
                            ^ n_lfsr[11] ^ n_lfsr[14] ^ n_lfsr[18] ^ n_lfsr[20]),
                            n_lv[1], n_lv[0]};
            end
            if (i_cmd.note && i_voice != 2'd3) begin
                if (i_command == tvpns_pkg::CMD_ON) begin
                    r_inc[i_voice] <= i_increment;
                    if (!i_voice[1]) begin
                        r_tgt[n_vsel] <= i_increment;
                        r_step[n_vsel] <= '0;
                    end else r_nen <= 1'b1;
                end else if (i_command == tvpns_pkg::CMD_OFF) begin
                    r_inc[i_voice] <= '0;
                    if (!i_voice[1]) begin
                        r_tgt[n_vsel] <= '0;
                        r_step[n_vsel] <= '0;
                    end else r_nen <= 1'b0;
                end
            end
            if (i_cmd.div_load) begin
                r_dv    <= n_vsel;
                r_dinc  <= n_mag;
                r_neg   <= n_diff[31];
                r_dnz   <= n_diff != 32'd0;
                r_tgt[n_vsel] <= i_increment;
                r_ticks <= (n_ticks == 24'd0) ? 24'd1 : n_ticks;
                r_rem   <= '0;
            end
            if (i_cmd.div_step) begin
                if (!n_trial[32]) r_rem <= n_trial;
                else r_rem <= {r_rem[31:0], r_dinc[31]};
                r_dinc <= {r_dinc[30:0], 1'b0};
                r_quo  <= {r_quo[30:0], !n_trial[32]};
            end
            if (i_cmd.div_done) begin
                if (r_quo == 32'd0)
                    r_step[r_dv] <= (!r_neg && r_dnz) ? 32'd1 : 32'hFFFF_FFFF;
                else
                    r_step[r_dv] <= r_neg ? 32'd0 - r_quo : r_quo;
            end
        end
    end
endmodule

### rtl/three_voice_pulse_noise_synth_top.sv
// Top level of the three-voice pulse/noise synth.
// Depends on tvpns_pkg, tvpns_ctrl, tvpns_dp and assert_macros.svh.
//
// Usage:
//  - Slave stream (s_axis_*): one beat per command. tuser = command,
//    tdata = {increment, voice} with voice in bits 1:0, increment in 33:2.
//  - Master stream (m_axis_*): one beat per sample tick, tdata bit 0 =
//    pulse0 level, bit 1 = pulse1 level, bit 2 = noise level.
//  - Config channel (i_cfg_*): register index and data, always ready;
//    write only while no command beat is in progress.
//  - Output: a tick beat's result is registered in the output register
//    on acceptance. A tick passes through ST_OUT; a plain note stays idle.
//  - A note on that starts a glide runs a 32-step restoring divider, one
//    quotient bit per cycle in ST_DIV; no beat is taken before ST_DIV_DONE ends.
//  - Ticks are held off (tready low) while the previous result has not
//    been taken; notes still pass. Reset clears all voices, loads the
//    noise seed and sets both duties to 128.
`include "assert_macros.svh"
module three_voice_pulse_noise_synth_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // voice[1:0], increment[33:2], zero pad
    input  logic [1:0]  s_axis_tuser,  // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // pulse0[0], pulse1[1], noise[2], zero pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    tvpns_pkg::t_cmd    w_cmd;
    tvpns_pkg::t_status w_status;
    logic               w_out_valid;
    logic [2:0]         w_levels;
    logic               w_out_take;

    // drain the output beat; a tick may refill it the same cycle
    assign w_out_take    = w_out_valid && m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {5'd0, w_levels};

    tvpns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_command  (s_axis_tuser),
        .i_out_free (!w_out_valid || m_axis_tready),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    tvpns_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_command   (s_axis_tuser),
        .i_voice     (s_axis_tdata[1:0]),
        .i_increment (s_axis_tdata[33:2]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_take  (w_out_take),
        .o_status    (w_status),
        .o_out_valid (w_out_valid),
        .o_levels    (w_levels)
    );

    `ASSERT_IMPL(a_tick_result, i_clk, i_rst_n, w_cmd.tick |=> m_axis_tvalid, "tick gave no beat")
    `ASSERT_NEVER(a_cmd_excl, i_clk, i_rst_n, w_cmd.tick && (w_cmd.div_step || w_cmd.note), "commands overlap")
    `ASSERT_IMPL(a_div_busy, i_clk, i_rst_n, w_cmd.div_step |-> !s_axis_tready, "input taken while dividing")
endmodule
